FILE: sv/spq_pkg.sv
// shared types, codes and defaults for the sorted priority queue
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] entry_priority;
        logic signed [31:0] entry_value;
    } spq_cmd_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] removed_value;
        logic signed [31:0] removed_priority;
        logic        [4:0]  occupancy;
    } spq_result_t;

    typedef struct packed {
        logic signed [31:0] entry_priority;
        logic signed [31:0] entry_value;
    } spq_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_RD,
        ST_INS_CMP,
        ST_REM_RD,
        ST_REM_WR,
        ST_DONE
    } spq_state_t;

    typedef struct packed {
        logic load;
        logic chk_full;
        logic chk_empty;
        logic ins_read;
        logic ins_shift;
        logic ins_place;
        logic rem_read;
        logic rem_move;
        logic rem_finish;
    } spq_ctrl_t;

    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
        logic idx_zero;
        logic shift;
        logic rem_last;
    } spq_stat_t;

endpackage

FILE: sv/spq_ctrl.sv
// controller state machine of the sorted priority queue
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_ctrl_t ctrl,
    output logic              busy,
    output logic              done
);

    spq_pkg::spq_state_t state_reg;
    spq_pkg::spq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = spq_pkg::ST_DISPATCH;
                end
            end
            spq_pkg::ST_DISPATCH:
            begin
                if (!stat.is_remove)
                begin
                    state_next = stat.full ? spq_pkg::ST_DONE : spq_pkg::ST_INS_RD;
                end
                else
                begin
                    state_next = stat.empty ? spq_pkg::ST_DONE : spq_pkg::ST_REM_RD;
                end
            end
            spq_pkg::ST_INS_RD:
            begin
                state_next = stat.idx_zero ? spq_pkg::ST_DONE : spq_pkg::ST_INS_CMP;
            end
            spq_pkg::ST_INS_CMP:
            begin
                state_next = stat.shift ? spq_pkg::ST_INS_RD : spq_pkg::ST_DONE;
            end
            spq_pkg::ST_REM_RD:
            begin
                state_next = spq_pkg::ST_REM_WR;
            end
            spq_pkg::ST_REM_WR:
            begin
                state_next = stat.rem_last ? spq_pkg::ST_DONE : spq_pkg::ST_REM_RD;
            end
            spq_pkg::ST_DONE:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // command decode
    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            spq_pkg::ST_DISPATCH:
            begin
                ctrl.chk_full  = !stat.is_remove && stat.full;
                ctrl.chk_empty = stat.is_remove && stat.empty;
            end
            spq_pkg::ST_INS_RD:
            begin
                ctrl.ins_place = stat.idx_zero;
                ctrl.ins_read  = !stat.idx_zero;
            end
            spq_pkg::ST_INS_CMP:
            begin
                ctrl.ins_shift = stat.shift;
                ctrl.ins_place = !stat.shift;
            end
            spq_pkg::ST_REM_RD:
            begin
                ctrl.rem_read = 1'b1;
            end
            spq_pkg::ST_REM_WR:
            begin
                ctrl.rem_move   = 1'b1;
                ctrl.rem_finish = stat.rem_last;
            end
            spq_pkg::ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: sv/spq_datapath.sv
// entry memory, count, index and result registers of the sorted priority queue
module spq_datapath #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::spq_cmd_t   cmd,
    input  spq_pkg::spq_ctrl_t  ctrl,
    output spq_pkg::spq_stat_t  stat,
    output spq_pkg::spq_result_t result
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    spq_pkg::spq_entry_t mem [QUEUE_DEPTH];

    spq_pkg::spq_cmd_t   cmd_reg;
    spq_pkg::spq_cmd_t   cmd_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       idx_next;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic signed [31:0]  rem_value_reg;
    logic signed [31:0]  rem_value_next;
    logic signed [31:0]  rem_prio_reg;
    logic signed [31:0]  rem_prio_next;
    spq_pkg::spq_entry_t rdata_reg;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    spq_pkg::spq_entry_t mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        status_reg    <= status_next;
        rem_value_reg <= rem_value_next;
        rem_prio_reg  <= rem_prio_next;
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        rem_value_next = rem_value_reg;
        rem_prio_next  = rem_prio_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = rdata_reg;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;

        if (ctrl.load)
        begin
            cmd_next       = cmd;
            status_next    = spq_pkg::STATUS_OK;
            rem_value_next = '0;
            rem_prio_next  = '0;
            // insert scans down from the tail, remove walks up from the head
            idx_next       = (cmd.mode == spq_pkg::MODE_INSERT) ? AW'(count_reg) : '0;
        end
        if (ctrl.chk_full)
        begin
            status_next = spq_pkg::STATUS_FULL;
        end
        if (ctrl.chk_empty)
        begin
            status_next = spq_pkg::STATUS_UNDERFLOW;
        end
        if (ctrl.ins_read)
        begin
            mem_re    = 1'b1;
            mem_raddr = idx_reg - AW'(1);
        end
        if (ctrl.ins_shift)
        begin
            mem_we    = 1'b1;
            mem_waddr = idx_reg;
            mem_wdata = rdata_reg;
            idx_next  = idx_reg - AW'(1);
        end
        if (ctrl.ins_place)
        begin
            mem_we                   = 1'b1;
            mem_waddr                = idx_reg;
            mem_wdata.entry_priority = cmd_reg.entry_priority;
            mem_wdata.entry_value    = cmd_reg.entry_value;
            count_next               = count_reg + CW'(1);
        end
        if (ctrl.rem_read)
        begin
            mem_re    = 1'b1;
            mem_raddr = idx_reg;
        end
        if (ctrl.rem_move)
        begin
            if (idx_reg == '0)
            begin
                rem_value_next = rdata_reg.entry_value;
                rem_prio_next  = rdata_reg.entry_priority;
            end
            else
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = rdata_reg;
            end
            idx_next = idx_reg + AW'(1);
        end
        if (ctrl.rem_finish)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign stat.is_remove = (cmd_reg.mode == spq_pkg::MODE_REMOVE);
    assign stat.full      = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.idx_zero  = (idx_reg == '0);
    assign stat.shift     = (rdata_reg.entry_priority > cmd_reg.entry_priority);
    assign stat.rem_last  = ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign result.status           = status_reg;
    assign result.removed_value    = rem_value_reg;
    assign result.removed_priority = rem_prio_reg;
    assign result.occupancy        = 5'(count_reg);

endmodule

FILE: sv/sorted_priority_queue.sv
// sorted priority queue top level: controller, datapath and checks
// Holds up to QUEUE_DEPTH entries, each a signed value with a signed priority, kept in
// ascending priority order in a single-port-write, registered-read memory. A transaction
// is accepted when start is high and busy is low; cmd.mode selects insert or remove. An
// insert goes behind every entry of lower or equal priority, so equal priorities leave in
// arrival order; a remove returns the front entry. Every transaction gives exactly one
// result, shown on result for the single cycle in which done is high; the receiver cannot
// hold it off, so capture it then. Status reports ok, underflow (remove when empty) or
// full (insert when full, entry dropped); occupancy is the entry count after the
// operation, truncated to five bits. An insert scans down from the tail and moves each
// stored entry of strictly greater priority one place back; when every stored entry
// moves, or the queue is empty, the scan stops at the head without a final compare. A
// remove takes the front entry and moves every other entry one place toward the head;
// full or underflow goes straight to done. As the memory read is registered, each shift
// step reads one entry and writes it one place over in the next cycle. Busy stays high
// until the done cycle ends, and the next transaction can be accepted in the cycle right
// after it. The memory needs no clearing after reset.
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  spq_pkg::spq_cmd_t    cmd,
    output logic                 done,
    output spq_pkg::spq_result_t result
);

    // command and status between the two halves
    spq_pkg::spq_ctrl_t ctrl;
    spq_pkg::spq_stat_t stat;

    spq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctrl   (ctrl),
        .stat   (stat),
        .result (result)
    );

`ifndef SYNTH
    // each transaction gives one single-cycle result strobe
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // the block only leaves idle on an accepted transaction
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // underflow leaves the queue empty
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == spq_pkg::STATUS_UNDERFLOW) |-> (result.occupancy == '0))
        else $error("underflow reported with entries held");

    // full leaves the queue at capacity
    a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == spq_pkg::STATUS_FULL)
            |-> (result.occupancy == 5'(QUEUE_DEPTH)))
        else $error("full reported below capacity");
`endif

endmodule
